[rtl/mppp_pkg.sv]
package mppp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_POST,
		ST_MAGN
	} state_t;

	// product being formed by the shared shift-add unit
	typedef enum logic [2:0] {
		OP_ERR_DT,
		OP_PROP,
		OP_DERIV,
		OP_INTEG,
		OP_SCALE
	} op_t;

	localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [2:0] REG_DERIV_GAIN  = 3'd1;
	localparam logic [2:0] REG_INTEG_GAIN  = 3'd2;
	localparam logic [2:0] REG_SCALE       = 3'd3;
	localparam logic [2:0] REG_DEADBAND    = 3'd4;

	localparam int MUL_STEPS = 32;
	localparam int CNT_W     = $clog2(MUL_STEPS);

	localparam logic [15:0] SCALE_RESET = 16'd256;
	localparam logic [7:0]  DUTY_MAX    = 8'd255;
	localparam logic [15:0] ERR_MAX     = 16'h7FFF;
	localparam logic [15:0] ERR_MIN     = 16'h8000;
	localparam logic [47:0] SUM_MAX     = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] SUM_MIN     = 48'h8000_0000_0000;
	localparam logic [60:0] TERM_SAT    = '1;
	localparam logic [63:0] MAG_CLAMP   = 64'h0000_0100_0000_0000;

endpackage

[rtl/motor_position_pid_pwm.sv]
// A request is taken only while idle; five 32-step shift-add multiplications on one shared
// multiplier run for it in turn (the 32-step divider runs alongside the first of them), and
// the result is loaded only once the output register is free of an unaccepted result.
// A finished result waits in the output register while the next request is taken.
// Reset clears the gains, offset, last error and integral, and sets the scale factor to 1.0.
module motor_position_pid_pwm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] encoder_count,
	input  logic [31:0] target_position,
	input  logic [7:0]  duty_limit,
	input  logic [15:0] elapsed_us,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  duty,
	output logic        forward_on,
	output logic        backward_on
);

	mppp_pkg::state_t state_q, state_d;
	mppp_pkg::op_t    op_q;
	logic [mppp_pkg::CNT_W-1:0] cnt_q;

	logic [31:0] prop_gain_q, deriv_gain_q, integ_gain_q;
	logic [15:0] scale_q;
	logic [7:0]  offset_q;

	logic [15:0] err_q, dt_q, last_error_q;
	logic [7:0]  limit_q;
	logic [47:0] error_sum_q;

	logic [31:0] num_q;
	logic [15:0] rem_q;
	logic        dneg_q;

	logic [47:0] mcand_q;
	logic [31:0] mplr_q;
	logic [79:0] acc_q;
	logic        pneg_q;
	logic [63:0] u_q;

	logic        out_valid_q, fwd_q;
	logic [7:0]  duty_q;

	logic        accept, mul_step, div_step, load_out, slot_free;
	logic [32:0] diff_in;
	logic [15:0] err_in, err_mag, dmag;
	logic [16:0] diff17;
	logic [31:0] pg_mag, dg_mag, ig_mag;
	logic [47:0] es_mag, inc;
	logic [48:0] mul_add, inc_s, sum49;
	logic [47:0] sum_sat;
	logic [16:0] div_shift, div_rem;
	logic        div_ge;
	logic [63:0] term_mag, term_s, u_sum, u_mag;
	logic [40:0] u_clamp;
	logic [32:0] raw;
	logic [7:0]  d1, duty_new;
	logic [8:0]  d2;

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// error, saturated to 16 bits
	assign diff_in = {encoder_count[31], encoder_count} - {target_position[31], target_position};
	always_comb begin
		if (diff_in[32:15] == '0 || diff_in[32:15] == '1) begin
			err_in = diff_in[15:0];
		end else begin
			err_in = diff_in[32] ? mppp_pkg::ERR_MIN : mppp_pkg::ERR_MAX;
		end
	end

	assign err_mag = err_q[15] ? (~err_q + 16'd1) : err_q;
	assign diff17  = {err_q[15], err_q} - {last_error_q[15], last_error_q};
	assign dmag    = diff17[16] ? 16'(~diff17 + 17'd1) : diff17[15:0];
	assign pg_mag  = prop_gain_q[31] ? (~prop_gain_q + 32'd1) : prop_gain_q;
	assign dg_mag  = deriv_gain_q[31] ? (~deriv_gain_q + 32'd1) : deriv_gain_q;
	assign ig_mag  = integ_gain_q[31] ? (~integ_gain_q + 32'd1) : integ_gain_q;
	assign es_mag  = error_sum_q[47] ? (~error_sum_q + 48'd1) : error_sum_q;

	// one multiplier bit per cycle, added at the top of the accumulator
	assign mul_add = {1'b0, acc_q[79:32]} + (mplr_q[0] ? {1'b0, mcand_q} : 49'd0);

	// restoring divider, one quotient bit per cycle
	assign div_shift = {rem_q, num_q[31]};
	assign div_ge    = div_shift >= {1'b0, dt_q};
	assign div_rem   = div_shift - {1'b0, dt_q};

	// integral update
	assign inc   = {acc_q[31:0], 16'h0000};
	assign inc_s = pneg_q ? (~{1'b0, inc} + 49'd1) : {1'b0, inc};
	assign sum49 = {error_sum_q[47], error_sum_q} + inc_s;
	always_comb begin
		if (sum49[48] != sum49[47]) begin
			sum_sat = sum49[48] ? mppp_pkg::SUM_MIN : mppp_pkg::SUM_MAX;
		end else begin
			sum_sat = sum49[47:0];
		end
	end

	// gain term to add into u, magnitude truncated (the integral term saturates instead)
	always_comb begin
		case (op_q)
			mppp_pkg::OP_PROP:  term_mag = {16'h0000, acc_q[47:0]};
			mppp_pkg::OP_DERIV: term_mag = {16'h0000, acc_q[63:16]};
			mppp_pkg::OP_INTEG: begin
				if (acc_q[79:77] != 3'b000) begin
					term_mag = {3'b000, mppp_pkg::TERM_SAT};
				end else begin
					term_mag = {3'b000, acc_q[76:16]};
				end
			end
			default: term_mag = '0;
		endcase
	end
	assign term_s = pneg_q ? (~term_mag + 64'd1) : term_mag;
	assign u_sum  = u_q + term_s;

	assign u_mag   = u_q[63] ? (~u_q + 64'd1) : u_q;
	assign u_clamp = (u_mag > mppp_pkg::MAG_CLAMP) ? mppp_pkg::MAG_CLAMP[40:0] : u_mag[40:0];

	// duty from the scaled magnitude
	assign raw      = acc_q[56:24];
	assign d1       = (raw > {25'd0, limit_q}) ? limit_q : raw[7:0];
	assign d2       = {1'b0, d1} + {1'b0, offset_q};
	assign duty_new = d2[8] ? mppp_pkg::DUTY_MAX : d2[7:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mppp_pkg::ST_IDLE: begin
				if (accept) state_d = mppp_pkg::ST_PREP;
			end
			mppp_pkg::ST_PREP: state_d = mppp_pkg::ST_MUL;
			mppp_pkg::ST_MUL: begin
				if (cnt_q == mppp_pkg::CNT_W'(mppp_pkg::MUL_STEPS - 1)) state_d = mppp_pkg::ST_POST;
			end
			mppp_pkg::ST_POST: begin
				unique case (op_q)
					mppp_pkg::OP_INTEG: state_d = mppp_pkg::ST_MAGN;
					mppp_pkg::OP_SCALE: begin
						if (slot_free) state_d = mppp_pkg::ST_IDLE;
					end
					default: state_d = mppp_pkg::ST_MUL;
				endcase
			end
			mppp_pkg::ST_MAGN: state_d = mppp_pkg::ST_MUL;
			default: state_d = mppp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != mppp_pkg::ST_IDLE);
		mul_step = (state_q == mppp_pkg::ST_MUL);
		div_step = mul_step && (op_q == mppp_pkg::OP_ERR_DT) && (dt_q != '0);
		load_out = (state_q == mppp_pkg::ST_POST) && (op_q == mppp_pkg::OP_SCALE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mppp_pkg::ST_IDLE;
			op_q         <= mppp_pkg::OP_ERR_DT;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			prop_gain_q  <= '0;
			deriv_gain_q <= '0;
			integ_gain_q <= '0;
			scale_q      <= mppp_pkg::SCALE_RESET;
			offset_q     <= '0;
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= mul_step ? (cnt_q + 1'b1) : '0;

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == mppp_pkg::ST_PREP) op_q <= mppp_pkg::OP_ERR_DT;
			if (state_q == mppp_pkg::ST_POST) begin
				unique case (op_q)
					mppp_pkg::OP_ERR_DT: begin
						op_q         <= mppp_pkg::OP_PROP;
						error_sum_q  <= sum_sat;
						last_error_q <= err_q;
					end
					mppp_pkg::OP_PROP:  op_q <= mppp_pkg::OP_DERIV;
					mppp_pkg::OP_DERIV: op_q <= mppp_pkg::OP_INTEG;
					mppp_pkg::OP_INTEG: op_q <= mppp_pkg::OP_SCALE;
					default: op_q <= op_q;
				endcase
			end

			if (cfg_wr_en) begin
				unique case (cfg_index)
					mppp_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
					mppp_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data;
					mppp_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg_data;
					mppp_pkg::REG_SCALE:      scale_q      <= cfg_data[15:0];
					mppp_pkg::REG_DEADBAND:   offset_q     <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q   <= err_in;
			dt_q    <= elapsed_us;
			limit_q <= duty_limit;
		end
		if (load_out) begin
			duty_q <= duty_new;
			fwd_q  <= !u_q[63];
		end
		unique case (state_q)
			mppp_pkg::ST_PREP: begin
				num_q   <= (dt_q != '0) ? {dmag, 16'h0000} : '0;
				rem_q   <= '0;
				dneg_q  <= diff17[16];
				mcand_q <= {32'h0, err_mag};
				mplr_q  <= {16'h0000, dt_q};
				acc_q   <= '0;
				pneg_q  <= err_q[15];
				u_q     <= '0;
			end
			mppp_pkg::ST_MUL: begin
				acc_q  <= {mul_add, acc_q[31:1]};
				mplr_q <= {1'b0, mplr_q[31:1]};
				if (div_step) begin
					rem_q <= div_ge ? div_rem[15:0] : div_shift[15:0];
					num_q <= {num_q[30:0], div_ge};
				end
			end
			mppp_pkg::ST_POST: begin
				u_q <= u_sum;
				unique case (op_q)
					mppp_pkg::OP_ERR_DT: begin
						mcand_q <= {32'h0, err_mag};
						mplr_q  <= pg_mag;
						pneg_q  <= err_q[15] ^ prop_gain_q[31];
						acc_q   <= '0;
					end
					mppp_pkg::OP_PROP: begin
						mcand_q <= {16'h0000, num_q};
						mplr_q  <= dg_mag;
						pneg_q  <= dneg_q ^ deriv_gain_q[31];
						acc_q   <= '0;
					end
					mppp_pkg::OP_DERIV: begin
						mcand_q <= es_mag;
						mplr_q  <= ig_mag;
						pneg_q  <= error_sum_q[47] ^ integ_gain_q[31];
						acc_q   <= '0;
					end
					default: ;
				endcase
			end
			mppp_pkg::ST_MAGN: begin
				mcand_q <= {7'h00, u_clamp};
				mplr_q  <= {16'h0000, scale_q};
				acc_q   <= '0;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign duty        = duty_q;
	assign forward_on  = fwd_q;
	assign backward_on = !fwd_q;

	a_out_from_scale: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == mppp_pkg::ST_POST && op_q == mppp_pkg::OP_SCALE))
		else $error("result raised outside the final scaling step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == mppp_pkg::ST_PREP)
		else $error("accepted request did not start the sequence");

	a_zero_dt_deriv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mppp_pkg::ST_POST && op_q == mppp_pkg::OP_ERR_DT && dt_q == '0)
		|-> num_q == '0)
		else $error("derivative not zero for zero elapsed time");

	a_mplr_spent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mppp_pkg::ST_POST |-> mplr_q == '0)
		else $error("multiplier bits left over at end of product");

endmodule
